@@ design/fss_pkg.sv @@
// shared constants and a case-folding helper for the fuzzy subsequence scorer
// no dependencies

package fss_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W = 6;
	localparam int SCORE_W = 11;
	localparam int POS_W = 3;
	localparam int ADD_W = 6;
	localparam int BYTES_PER_WORD = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD0 = 3'd1;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [ADD_W-1:0] PTS_MATCH = 6'd10;
	localparam logic [ADD_W-1:0] PTS_WORD_START = 6'd20;
	localparam logic [ADD_W-1:0] PTS_CHAIN = 6'd5;
	localparam logic [ADD_W-1:0] PTS_EARLY = 6'd10;
	localparam logic [POS_W-1:0] EARLY_BYTES = 3'd5;

	// ascii letters only fold to lower case
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

@@ design/fuzzy_subsequence_scorer.sv @@
// fuzzy subsequence scorer: input register, per-byte scoring, result register
// a result is written to the result register as the last name byte leaves the input register
// throughput: one name byte per cycle, except while a last byte waits for an unclaimed result
// reset clears the query, per-name state and both valid flags; ready for bytes at once
// depends on fss_pkg and fss_query_regs

module fuzzy_subsequence_scorer #(
	parameter int MAX_QUERY = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           name_byte,
	input  logic                                 name_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [fss_pkg::SCORE_W-1:0]          match_score,
	output logic                                 is_match,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import fss_pkg::*;

	localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

	logic [LEN_W-1:0]           active_len;
	logic [MAX_QUERY-1:0][7:0]  query_chars;

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic                       end_s1;

	logic [LEN_W-1:0]           matched_q;
	logic [SCORE_W-1:0]         score_q;
	logic [7:0]                 prior_q;
	logic [POS_W-1:0]           pos_q;

	logic [SCORE_W-1:0]         score_out_q;
	logic                       match_out_q;
	logic                       out_valid_q;

	logic                       advance;
	logic                       hit;
	logic                       first;
	logic                       after_sep;
	logic                       chain;
	logic [IDX_W-1:0]           cur_idx;
	logic [IDX_W-1:0]           prev_idx;
	logic [ADD_W-1:0]           add;
	logic [LEN_W-1:0]           matched_nxt;
	logic [SCORE_W-1:0]         score_nxt;
	logic                       ok;

	fss_query_regs #(
		.MAX_QUERY(MAX_QUERY)
	) u_query (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.active_len (active_len),
		.query_chars(query_chars)
	);

	assign cfg_ready = 1'b1;

	// a last byte waits only while the previous result is still unclaimed
	assign advance = valid_s1 && !(end_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= name_byte;
			end_s1 <= name_end;
		end
	end

	assign cur_idx = matched_q[IDX_W-1:0];
	assign prev_idx = IDX_W'(matched_q - LEN_W'(1));
	assign first = (pos_q == '0);
	assign after_sep = (prior_q == CH_SLASH) || (prior_q == CH_UNDERSCORE) ||
		(prior_q == CH_DASH);

	always_comb begin
		hit = 1'b0;
		chain = 1'b0;
		if (matched_q < active_len) begin
			hit = (fold_case(query_chars[cur_idx]) == fold_case(byte_s1));
			chain = (matched_q != '0) && !first &&
				(fold_case(query_chars[prev_idx]) == fold_case(prior_q));
		end
	end

	always_comb begin
		add = PTS_MATCH;
		if (first || after_sep) begin
			add = add + PTS_WORD_START;
		end
		if (chain) begin
			add = add + PTS_CHAIN;
		end
		if (pos_q < EARLY_BYTES) begin
			add = add + PTS_EARLY;
		end
	end

	assign matched_nxt = hit ? matched_q + LEN_W'(1) : matched_q;
	assign score_nxt = hit ? score_q + SCORE_W'(add) : score_q;
	assign ok = (active_len != '0) && (matched_nxt >= active_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= '0;
			score_q <= '0;
			prior_q <= '0;
			pos_q <= '0;
		end else if (advance) begin
			if (end_s1) begin
				matched_q <= '0;
				score_q <= '0;
				prior_q <= '0;
				pos_q <= '0;
			end else begin
				matched_q <= matched_nxt;
				score_q <= score_nxt;
				prior_q <= byte_s1;
				if (pos_q < EARLY_BYTES) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			score_out_q <= ok ? score_nxt : '0;
			match_out_q <= ok;
		end
	end

	assign out_valid = out_valid_q;
	assign match_score = score_out_q;
	assign is_match = match_out_q;

endmodule

@@ design/fss_query_regs.sv @@
// query configuration registers: length and query characters
// depends on fss_pkg

module fss_query_regs #(
	parameter int MAX_QUERY = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic [fss_pkg::LEN_W-1:0]            active_len,
	output logic [MAX_QUERY-1:0][7:0]            query_chars
);
	import fss_pkg::*;

	logic [LEN_W-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_valid && cfg_index == CFG_QUERY_LENGTH) begin
			len_q <= cfg_data[LEN_W-1:0];
		end
	end

	// only the characters that fit MAX_QUERY are kept
	for (genvar k = 0; k < MAX_QUERY; k++) begin : g_char
		localparam logic [CFG_IDX_W-1:0] WORD_IDX =
			CFG_IDX_W'(int'(CFG_QUERY_WORD0) + k / BYTES_PER_WORD);
		localparam int LANE = k % BYTES_PER_WORD;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				query_chars[k] <= '0;
			end else if (cfg_valid && cfg_index == WORD_IDX) begin
				query_chars[k] <= cfg_data[LANE*8 +: 8];
			end
		end
	end

	assign active_len = (len_q > LEN_W'(MAX_QUERY)) ? LEN_W'(MAX_QUERY) : len_q;

endmodule
